### rtl/mdc_pkg.sv
package mdc_pkg;

  // default largest side of the maze
  localparam int SIDE_MAX_DEF = 64;

  // configuration register
  localparam int CFG_W     = 7;
  localparam int SIDE_RST  = 8;

  // beat field widths
  localparam int PICK_W    = 8;
  localparam int COORD_W   = 6;
  localparam int IN_DATA_W = 8;
  localparam int OUT_DATA_W = 32;

  // result action codes
  typedef enum logic [1:0] {
    ACT_CARVE = 2'd0,
    ACT_BACK  = 2'd1,
    ACT_IDLE  = 2'd2,
    ACT_START = 2'd3
  } act_t;

  // neighbour direction codes, also the search order
  typedef enum logic [1:0] {
    DIR_RIGHT = 2'd0,
    DIR_LEFT  = 2'd1,
    DIR_UP    = 2'd2,
    DIR_DOWN  = 2'd3
  } dir_t;

  // input item kinds
  typedef enum logic {
    KIND_START = 1'b0,
    KIND_STEP  = 1'b1
  } kind_t;

endpackage

### rtl/maze_dfs_carver.sv
// sequence: a step with an open neighbor runs stack read, four visited reads, the bit-serial
//   remainder of the pick, write-back and output; a step with no open neighbor skips the
//   remainder; a step on an empty stack goes straight to output; a start runs the clearing
//   sweep of the memories, one room per cycle, before its output
// throughput: one item at a time; next beat taken back in idle, later if out_tready holds off
// reset: sync active-low rst_n clears sequencer, stack count, out valid; rooms_per_side 8
module maze_dfs_carver #(
  parameter int SIDE_MAX = mdc_pkg::SIDE_MAX_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [mdc_pkg::IN_DATA_W-1:0]   in_tdata,   // [7:0] random_pick
  input  logic                            in_tuser,   // [0] kind
  // result stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [mdc_pkg::OUT_DATA_W-1:0]  out_tdata,  // cur_row, cur_col, next_row,
                                                      // next_col, wall_dir, zero pad
  output logic [1:0]                      out_tuser,  // [1:0] action
  // configuration
  input  logic                            cfg_we,
  input  logic [mdc_pkg::CFG_W-1:0]       cfg_wdata   // rooms_per_side
);

  localparam int CW        = $clog2(SIDE_MAX);
  localparam int AW        = 2 * CW;
  localparam int MEM_DEPTH = 1 << AW;
  localparam int ROOMS     = SIDE_MAX * SIDE_MAX;
  localparam int SCW       = $clog2(ROOMS + 1);
  localparam int SIW       = $clog2(ROOMS);
  localparam int SW        = $clog2(SIDE_MAX + 1);
  localparam int XW        = SW + 1;
  localparam int EW        = (SW > mdc_pkg::CFG_W) ? SW : mdc_pkg::CFG_W;
  localparam int OW        = mdc_pkg::COORD_W;
  localparam int PW        = mdc_pkg::PICK_W;
  localparam int DCW       = $clog2(PW);

  typedef enum logic [3:0] {
    S_IDLE, S_CLEAR, S_TOP, S_RD, S_CAP, S_PICK, S_DIV, S_APPLY, S_EMIT
  } state_t;

  state_t                   state_r;
  logic [mdc_pkg::CFG_W-1:0] side_cfg_r;
  logic [SW-1:0]            side_r;
  logic [SCW-1:0]           count_r;
  logic [AW-1:0]            clr_r;
  logic [CW-1:0]            cur_row_r, cur_col_r;
  logic [1:0]               nb_r;
  logic [3:0]               cand_r;
  logic [PW-1:0]            pick_r;
  logic [1:0]               rem_r;
  logic [DCW-1:0]           div_cnt_r;
  logic                     out_valid_r;
  logic [mdc_pkg::OUT_DATA_W-1:0] out_data_r;
  logic [1:0]               out_user_r;
  logic [OW-1:0]            res_cr_r, res_cc_r, res_nr_r, res_nc_r;
  logic [1:0]               res_act_r, res_dir_r;

  // memories
  logic                     visited_map [MEM_DEPTH];
  logic                     right_open  [MEM_DEPTH];
  logic                     down_open   [MEM_DEPTH];
  logic [AW-1:0]            path_stack  [ROOMS];
  logic                     vis_rd_r;
  logic [AW-1:0]            stk_rd_r;

  logic                     in_fire;
  logic                     start_fire;
  logic [SW-1:0]            side_eff;
  logic [SCW-1:0]           cnt_m1;
  logic [AW-1:0]            cur_addr, nxt_addr, start_addr;
  logic [XW-1:0]            rx, cx, nx;
  logic                     nb_ok  [4];
  logic [CW-1:0]            nb_row [4];
  logic [CW-1:0]            nb_col [4];
  logic [2:0]               cand_cnt;
  logic [2:0]               div_t;
  logic [1:0]               sel_dir;
  logic                     carve;
  logic                     vis_we, vis_wdata;
  logic [AW-1:0]            vis_waddr, vis_raddr;
  logic                     rgt_we, rgt_wdata, dn_we, dn_wdata;
  logic [AW-1:0]            rgt_waddr, dn_waddr;
  logic                     stk_we;
  logic [SIW-1:0]           stk_waddr, stk_raddr;
  logic [AW-1:0]            stk_wdata;

  // handshake
  assign in_tready  = (state_r == S_IDLE) && rst_n;
  assign in_fire    = in_tvalid && in_tready;
  assign start_fire = in_fire && (in_tuser == mdc_pkg::KIND_START);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // effective side: zero acts as one, large values clamp to the maximum
  always_comb begin
    if (side_cfg_r == '0) begin
      side_eff = SW'(1);
    end else if (EW'(side_cfg_r) > EW'(SIDE_MAX)) begin
      side_eff = SW'(SIDE_MAX);
    end else begin
      side_eff = SW'(side_cfg_r);
    end
  end

  assign start_addr = {CW'(side_eff - SW'(1)), CW'(0)};
  assign cnt_m1     = count_r - SCW'(1);
  assign stk_raddr  = cnt_m1[SIW-1:0];
  assign cur_addr   = {cur_row_r, cur_col_r};

  // neighbor bounds and coordinates in search order
  assign rx = XW'(cur_row_r);
  assign cx = XW'(cur_col_r);
  assign nx = XW'(side_r);
  always_comb begin
    nb_ok[mdc_pkg::DIR_RIGHT]  = (rx < nx) && (cx + XW'(1) < nx);
    nb_row[mdc_pkg::DIR_RIGHT] = cur_row_r;
    nb_col[mdc_pkg::DIR_RIGHT] = cur_col_r + CW'(1);
    nb_ok[mdc_pkg::DIR_LEFT]   = (rx < nx) && (cx != '0) && (cx - XW'(1) < nx);
    nb_row[mdc_pkg::DIR_LEFT]  = cur_row_r;
    nb_col[mdc_pkg::DIR_LEFT]  = cur_col_r - CW'(1);
    nb_ok[mdc_pkg::DIR_UP]     = (cx < nx) && (rx != '0) && (rx - XW'(1) < nx);
    nb_row[mdc_pkg::DIR_UP]    = cur_row_r - CW'(1);
    nb_col[mdc_pkg::DIR_UP]    = cur_col_r;
    nb_ok[mdc_pkg::DIR_DOWN]   = (cx < nx) && (rx + XW'(1) < nx);
    nb_row[mdc_pkg::DIR_DOWN]  = cur_row_r + CW'(1);
    nb_col[mdc_pkg::DIR_DOWN]  = cur_col_r;
  end

  assign vis_raddr = {nb_row[nb_r], nb_col[nb_r]};

  // candidate count and restoring modulo step
  assign cand_cnt = 3'(cand_r[0]) + 3'(cand_r[1]) + 3'(cand_r[2]) + 3'(cand_r[3]);
  assign div_t    = {rem_r, pick_r[PW-1]};

  // pick the candidate whose rank equals the remainder
  always_comb begin
    logic [2:0] seen;
    seen    = '0;
    sel_dir = mdc_pkg::DIR_RIGHT;
    for (int i = 0; i < 4; i++) begin
      if (cand_r[i] && (seen == 3'(rem_r))) begin
        sel_dir = 2'(i);
      end
      seen = seen + 3'(cand_r[i]);
    end
  end

  assign carve    = (cand_cnt != '0) && (SCW'(count_r) < SCW'(ROOMS));
  assign nxt_addr = {nb_row[sel_dir], nb_col[sel_dir]};

  // memory write ports
  always_comb begin
    vis_we    = (state_r == S_CLEAR) || (state_r == S_APPLY);
    vis_waddr = (state_r == S_CLEAR) ? clr_r : cur_addr;
    vis_wdata = (state_r == S_APPLY);

    rgt_we    = (state_r == S_CLEAR) ||
                ((state_r == S_APPLY) && carve &&
                 ((sel_dir == mdc_pkg::DIR_RIGHT) || (sel_dir == mdc_pkg::DIR_LEFT)));
    rgt_waddr = (state_r == S_CLEAR) ? clr_r :
                (sel_dir == mdc_pkg::DIR_RIGHT) ? cur_addr : nxt_addr;
    rgt_wdata = (state_r != S_CLEAR);

    dn_we     = (state_r == S_CLEAR) ||
                ((state_r == S_APPLY) && carve &&
                 ((sel_dir == mdc_pkg::DIR_UP) || (sel_dir == mdc_pkg::DIR_DOWN)));
    dn_waddr  = (state_r == S_CLEAR) ? clr_r :
                (sel_dir == mdc_pkg::DIR_DOWN) ? cur_addr : nxt_addr;
    dn_wdata  = (state_r != S_CLEAR);

    stk_we    = start_fire || ((state_r == S_APPLY) && carve);
    stk_waddr = start_fire ? SIW'(0) : count_r[SIW-1:0];
    stk_wdata = start_fire ? start_addr : nxt_addr;
  end

  // visited map and wall memories
  always_ff @(posedge clk) begin
    if (vis_we) begin
      visited_map[vis_waddr] <= vis_wdata;
    end
    vis_rd_r <= visited_map[vis_raddr];
    if (rgt_we) begin
      right_open[rgt_waddr] <= rgt_wdata;
    end
    if (dn_we) begin
      down_open[dn_waddr] <= dn_wdata;
    end
  end

  // path stack
  always_ff @(posedge clk) begin
    if (stk_we) begin
      path_stack[stk_waddr] <= stk_wdata;
    end
    stk_rd_r <= path_stack[stk_raddr];
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      side_cfg_r  <= mdc_pkg::CFG_W'(mdc_pkg::SIDE_RST);
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // configuration write
      if (cfg_we) begin
        side_cfg_r <= cfg_wdata;
      end

      // output beat taken, unless a new one is loaded below
      if (out_valid_r && out_tready && (state_r != S_EMIT)) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            side_r <= side_eff;
            pick_r <= in_tdata[PW-1:0];
            if (in_tuser == mdc_pkg::KIND_START) begin
              count_r   <= SCW'(1);
              clr_r     <= '0;
              res_cr_r  <= OW'(start_addr[AW-1:CW]);
              res_cc_r  <= '0;
              res_nr_r  <= OW'(start_addr[AW-1:CW]);
              res_nc_r  <= '0;
              res_act_r <= mdc_pkg::ACT_START;
              res_dir_r <= mdc_pkg::DIR_RIGHT;
              state_r   <= S_CLEAR;
            end else if (count_r == '0) begin
              res_cr_r  <= '0;
              res_cc_r  <= '0;
              res_nr_r  <= '0;
              res_nc_r  <= '0;
              res_act_r <= mdc_pkg::ACT_IDLE;
              res_dir_r <= mdc_pkg::DIR_RIGHT;
              state_r   <= S_EMIT;
            end else begin
              state_r <= S_TOP;
            end
          end
        end

        // clearing sweep, one room per cycle
        S_CLEAR: begin
          clr_r <= clr_r + AW'(1);
          if (clr_r == '1) begin
            state_r <= S_EMIT;
          end
        end

        // stack top is ready
        S_TOP: begin
          cur_row_r <= stk_rd_r[AW-1:CW];
          cur_col_r <= stk_rd_r[CW-1:0];
          nb_r      <= mdc_pkg::DIR_RIGHT;
          state_r   <= S_RD;
        end

        // visited read of one neighbor in flight
        S_RD: begin
          state_r <= S_CAP;
        end

        S_CAP: begin
          cand_r[nb_r] <= nb_ok[nb_r] && !vis_rd_r;
          nb_r         <= nb_r + 2'd1;
          if (nb_r == mdc_pkg::DIR_DOWN) begin
            state_r <= S_PICK;
          end else begin
            state_r <= S_RD;
          end
        end

        S_PICK: begin
          rem_r     <= '0;
          div_cnt_r <= '0;
          if (cand_cnt == '0) begin
            state_r <= S_APPLY;
          end else begin
            state_r <= S_DIV;
          end
        end

        // bit-serial remainder of the pick by the candidate count
        S_DIV: begin
          if (div_t >= cand_cnt) begin
            rem_r <= 2'(div_t - cand_cnt);
          end else begin
            rem_r <= div_t[1:0];
          end
          pick_r    <= {pick_r[PW-2:0], 1'b0};
          div_cnt_r <= div_cnt_r + DCW'(1);
          if (div_cnt_r == DCW'(PW - 1)) begin
            state_r <= S_APPLY;
          end
        end

        // write back, push or pop
        S_APPLY: begin
          res_cr_r <= OW'(cur_row_r);
          res_cc_r <= OW'(cur_col_r);
          if (carve) begin
            count_r   <= count_r + SCW'(1);
            res_nr_r  <= OW'(nb_row[sel_dir]);
            res_nc_r  <= OW'(nb_col[sel_dir]);
            res_act_r <= mdc_pkg::ACT_CARVE;
            res_dir_r <= sel_dir;
          end else begin
            count_r   <= cnt_m1;
            res_nr_r  <= OW'(cur_row_r);
            res_nc_r  <= OW'(cur_col_r);
            res_act_r <= mdc_pkg::ACT_BACK;
            res_dir_r <= mdc_pkg::DIR_RIGHT;
          end
          state_r <= S_EMIT;
        end

        // hand the result to the output register once it is free
        S_EMIT: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_data_r  <= mdc_pkg::OUT_DATA_W'({res_dir_r, res_nc_r, res_nr_r,
                                                 res_cc_r, res_cr_r});
            out_user_r  <= res_act_r;
            state_r     <= S_IDLE;
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule
